@@ sv/hed_pkg.sv @@
// Shared types, character codes and entity tables for the HTML entity decoder.
// Used by the controller, the datapath and the top level.
`default_nettype none
package hed_pkg;

  localparam int MAX_SPAN_DEF = 20;
  localparam int OUT_LIMIT    = 24;
  localparam int EW           = $clog2(OUT_LIMIT + 1);
  localparam int NAME_COUNT   = 18;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QMARK = 8'h3f;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } hed_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } hed_out_t;

  typedef enum logic [2:0] {
    ES_AMP,
    ES_SEMI,
    ES_TEXT,
    ES_NUM,
    ES_RAM
  } hed_esel_t;

  // numeric form parser, one step per held byte after the hash
  typedef enum logic [6:0] {
    NP_BASE = 7'b0000001,
    NP_WS   = 7'b0000010,
    NP_PFX  = 7'b0000100,
    NP_ZERO = 7'b0001000,
    NP_ZX   = 7'b0010000,
    NP_DIG  = 7'b0100000,
    NP_DONE = 7'b1000000
  } hed_np_t;

  typedef struct packed {
    logic      accept;
    logic      take_in;
    logic      take_ram;
    logic      emit_en;
    hed_esel_t emit_sel;
    logic      ri_inc;
    logic      close;
    logic      rp_start;
    logic      flush;
  } hed_cmd_t;

  typedef struct packed {
    logic semi;
    logic ovf;
    logic name_hit;
    logic is_hash;
    logic ri_at_len;
    logic ri_at_cnt;
    logic txt_last;
    logic emit_ok;
    logic flush_ok;
    logic in_ent;
    logic last;
    logic p_valid;
  } hed_stat_t;

  function automatic logic [7:0] lower8(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  // names left-justified, zero padded
  function automatic logic [47:0] name_str(input logic [4:0] k);
    logic [47:0] s;
    case (k)
      5'd0:    s = {"amp", 24'd0};
      5'd1:    s = {"lt", 32'd0};
      5'd2:    s = {"gt", 32'd0};
      5'd3:    s = {"quot", 16'd0};
      5'd4:    s = {"apos", 16'd0};
      5'd5:    s = {"nbsp", 16'd0};
      5'd6:    s = {"copy", 16'd0};
      5'd7:    s = {"reg", 24'd0};
      5'd8:    s = {"mdash", 8'd0};
      5'd9:    s = {"ndash", 8'd0};
      5'd10:   s = "hellip";
      5'd11:   s = {"bull", 16'd0};
      5'd12:   s = {"laquo", 8'd0};
      5'd13:   s = {"raquo", 8'd0};
      5'd14:   s = {"euro", 16'd0};
      5'd15:   s = {"pound", 8'd0};
      5'd16:   s = {"yen", 24'd0};
      5'd17:   s = {"cent", 16'd0};
      default: s = 48'd0;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] name_len(input logic [4:0] k);
    logic [2:0] n;
    case (k)
      5'd1, 5'd2:                                  n = 3'd2;
      5'd0, 5'd7, 5'd16:                           n = 3'd3;
      5'd3, 5'd4, 5'd5, 5'd6, 5'd11, 5'd14, 5'd17: n = 3'd4;
      5'd8, 5'd9, 5'd12, 5'd13, 5'd15:             n = 3'd5;
      5'd10:                                       n = 3'd6;
      default:                                     n = 3'd7;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] name_ch(input logic [4:0] k, input logic [2:0] pos);
    logic [47:0] s;
    s = name_str(k) << {pos, 3'b000};
    return s[47:40];
  endfunction

  function automatic logic [23:0] text_str(input logic [4:0] k);
    logic [23:0] s;
    case (k)
      5'd0:    s = {"&", 16'd0};
      5'd1:    s = {"<", 16'd0};
      5'd2:    s = {">", 16'd0};
      5'd3:    s = {"\"", 16'd0};
      5'd4:    s = {"'", 16'd0};
      5'd5:    s = {" ", 16'd0};
      5'd6:    s = "(c)";
      5'd7:    s = "(r)";
      5'd8:    s = {"--", 8'd0};
      5'd9:    s = {"-", 16'd0};
      5'd10:   s = "...";
      5'd11:   s = {"*", 16'd0};
      5'd12:   s = {"<<", 8'd0};
      5'd13:   s = {">>", 8'd0};
      5'd14:   s = "EUR";
      5'd15:   s = "GBP";
      5'd16:   s = "JPY";
      5'd17:   s = {"c", 16'd0};
      default: s = 24'd0;
    endcase
    return s;
  endfunction

  function automatic logic [1:0] text_len(input logic [4:0] k);
    logic [1:0] n;
    case (k)
      5'd6, 5'd7, 5'd10, 5'd14, 5'd15, 5'd16: n = 2'd3;
      5'd8, 5'd12, 5'd13:                     n = 2'd2;
      default:                                n = 2'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] text_ch(input logic [4:0] k, input logic [1:0] idx);
    logic [23:0] s;
    s = text_str(k) << {idx, 3'b000};
    return s[23:16];
  endfunction

endpackage
`default_nettype wire

@@ sv/hed_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module hed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 20
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ sv/hed_ctrl.sv @@
// Sequencer for the HTML entity decoder: accepts items, walks resolve,
// replay and flush steps. Depends on hed_pkg.
`default_nettype none
module hed_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire hed_pkg::hed_stat_t stat,
  output hed_pkg::hed_cmd_t       cmd
);
  import hed_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RES   = 9'b000000010,
    S_UNRD  = 9'b000000100,
    S_UNUSE = 9'b000001000,
    S_RPS   = 9'b000010000,
    S_RPRD  = 9'b000100000,
    S_RPUSE = 9'b001000000,
    S_CHK   = 9'b010000000,
    S_FLUSH = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept  = 1'b1;
          cmd.take_in = !stat.semi;
          if (stat.semi)     state_nxt = S_RES;
          else if (stat.ovf) state_nxt = S_RPS;
          else               state_nxt = S_CHK;
        end
      end
      S_RES: begin
        if (stat.emit_ok) begin
          cmd.emit_en = 1'b1;
          if (stat.name_hit) begin
            cmd.emit_sel = ES_TEXT;
            if (stat.txt_last) begin
              cmd.close = 1'b1;
              state_nxt = S_CHK;
            end else begin
              cmd.ri_inc = 1'b1;
            end
          end else if (stat.is_hash) begin
            cmd.emit_sel = ES_NUM;
            cmd.close    = 1'b1;
            state_nxt    = S_CHK;
          end else begin
            cmd.emit_sel = ES_AMP;
            state_nxt    = S_UNRD;
          end
        end
      end
      S_UNRD: begin
        if (!stat.ri_at_cnt) begin
          state_nxt = S_UNUSE;
        end else if (stat.emit_ok) begin
          cmd.emit_en  = 1'b1;
          cmd.emit_sel = ES_SEMI;
          cmd.close    = 1'b1;
          state_nxt    = S_CHK;
        end
      end
      S_UNUSE: begin
        if (stat.emit_ok) begin
          cmd.emit_en  = 1'b1;
          cmd.emit_sel = ES_RAM;
          cmd.ri_inc   = 1'b1;
          state_nxt    = S_UNRD;
        end
      end
      S_RPS: begin
        if (stat.emit_ok) begin
          cmd.emit_en  = 1'b1;
          cmd.emit_sel = ES_AMP;
          cmd.rp_start = 1'b1;
          state_nxt    = S_RPRD;
        end
      end
      S_RPRD: begin
        state_nxt = stat.ri_at_len ? S_CHK : S_RPUSE;
      end
      S_RPUSE: begin
        // feed one held item back through the decoder
        if (stat.emit_ok) begin
          cmd.take_ram = 1'b1;
          cmd.ri_inc   = 1'b1;
          state_nxt    = S_RPRD;
        end
      end
      S_CHK: begin
        state_nxt = (stat.last && stat.in_ent) ? S_RPS : S_FLUSH;
      end
      S_FLUSH: begin
        if (stat.flush_ok) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/hed_dp.sv @@
// Datapath of the HTML entity decoder: span RAM, name and number matchers,
// pending and output registers. Depends on hed_pkg and hed_ram.
`default_nettype none
module hed_dp #(
  parameter int MAX_SPAN = hed_pkg::MAX_SPAN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hed_pkg::hed_in_t  in_data,
  input  wire hed_pkg::hed_cmd_t cmd,
  output hed_pkg::hed_stat_t     stat,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output hed_pkg::hed_out_t      out_data
);
  import hed_pkg::*;

  localparam int CW = $clog2(MAX_SPAN + 1);
  localparam int AW = $clog2(MAX_SPAN);

  logic                  in_ent_r, in_ent_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         ri_r, ri_nxt;
  logic [CW-1:0]         len_r, len_nxt;
  logic                  last_r, last_nxt;
  logic [EW-1:0]         ecnt_r, ecnt_nxt;
  logic                  p_valid_r, p_valid_nxt;
  logic [7:0]            p_byte_r, p_byte_nxt;
  logic                  out_valid_r, out_valid_nxt;
  hed_out_t              out_data_r, out_data_nxt;
  logic [NAME_COUNT-1:0] mask_r, mask_nxt;
  logic                  is_hash_r, is_hash_nxt;
  hed_np_t               np_r, np_nxt;
  logic                  b16_r, b16_nxt;
  logic                  neg_r, neg_nxt;
  logic [7:0]            mag_r, mag_nxt;

  logic                  take;
  logic [7:0]            tb, lc, rd_data, em_b, sel_b, num_b;
  logic                  ram_we, em_req, do_emit, emit_ok, hit;
  logic [4:0]            hit_idx;
  logic [EW-1:0]         ecnt_base;
  logic [NAME_COUNT-1:0] mask_upd;

  // numeric parse step results
  hed_np_t    ps_np;
  logic       ps_b16, ps_neg, consumed, d_ok;
  logic [7:0] ps_mag;
  logic [3:0] d_val;
  logic [11:0] prod;

  hed_ram #(.WIDTH(8), .DEPTH(MAX_SPAN)) u_span (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (tb),
    .raddr (ri_r[AW-1:0]),
    .rdata (rd_data)
  );

  assign take = cmd.take_in | cmd.take_ram;
  assign tb   = cmd.take_ram ? rd_data : in_data.text_byte;
  assign lc   = lower8(tb);

  always_comb begin
    hit     = 1'b0;
    hit_idx = 5'd0;
    for (int k = 0; k < NAME_COUNT; k++) begin
      if (!hit && mask_r[k] && cnt_r == CW'(name_len(5'(k)))) begin
        hit     = 1'b1;
        hit_idx = 5'(k);
      end
      mask_upd[k] = mask_r[k] && (cnt_r < CW'(name_len(5'(k)))) &&
                    (lc == name_ch(5'(k), cnt_r[2:0]));
    end
  end

  assign num_b = (!neg_r && mag_r != 8'd0 && !mag_r[7]) ? mag_r : CH_QMARK;

  always_comb begin
    case (cmd.emit_sel)
      ES_AMP:  sel_b = CH_AMP;
      ES_SEMI: sel_b = CH_SEMI;
      ES_TEXT: sel_b = text_ch(hit_idx, ri_r[1:0]);
      ES_NUM:  sel_b = num_b;
      ES_RAM:  sel_b = rd_data;
      default: sel_b = CH_QMARK;
    endcase
  end

  // digit value of the current byte in the current base
  always_comb begin
    d_ok  = 1'b0;
    d_val = 4'd0;
    if (tb >= "0" && tb <= "9") begin
      d_ok  = 1'b1;
      d_val = tb[3:0];
    end else if (b16_r && lc >= "a" && lc <= "f") begin
      d_ok  = 1'b1;
      d_val = 4'(lc - "a" + 8'd10);
    end
  end

  always_comb begin
    ps_np    = np_r;
    ps_b16   = b16_r;
    ps_neg   = neg_r;
    ps_mag   = mag_r;
    consumed = 1'b0;
    prod     = b16_r ? {mag_r, 4'b0000} : ({1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0});
    prod     = prod + {8'd0, d_val};
    if (ps_np == NP_BASE) begin
      if (lc == "x") begin
        ps_b16   = 1'b1;
        consumed = 1'b1;
      end
      ps_np = NP_WS;
    end
    if (!consumed && ps_np == NP_WS) begin
      if (tb == " " || (tb >= 8'd9 && tb <= 8'd13)) begin
        consumed = 1'b1;
      end else if (tb == "+" || tb == "-") begin
        ps_neg   = (tb == "-");
        ps_np    = NP_PFX;
        consumed = 1'b1;
      end else begin
        ps_np = NP_PFX;
      end
    end
    if (!consumed && ps_np == NP_PFX) begin
      if (ps_b16 && tb == "0") begin
        ps_mag   = 8'd0;
        ps_np    = NP_ZERO;
        consumed = 1'b1;
      end else begin
        ps_np = NP_DIG;
      end
    end
    if (!consumed && ps_np == NP_ZERO) begin
      if (lc == "x") begin
        ps_np    = NP_ZX;
        consumed = 1'b1;
      end else begin
        ps_np = NP_DIG;
      end
    end
    if (!consumed && ps_np == NP_ZX) begin
      // 0x counts as a prefix only when a hex digit follows
      if (d_ok) begin
        ps_mag = {4'd0, d_val};
        ps_np  = NP_DIG;
      end else begin
        ps_np = NP_DONE;
      end
      consumed = 1'b1;
    end
    if (!consumed && ps_np == NP_DIG) begin
      if (d_ok) begin
        ps_mag = (prod > 12'd128) ? 8'd128 : prod[7:0];
      end else begin
        ps_np = NP_DONE;
      end
    end
  end

  assign emit_ok   = !p_valid_r || !out_valid_r || out_ready;
  assign em_req    = cmd.emit_en | (take && !in_ent_r && tb != CH_AMP);
  assign em_b      = cmd.emit_en ? sel_b : tb;
  assign ecnt_base = cmd.accept ? EW'(0) : ecnt_r;
  assign do_emit   = em_req && (ecnt_base < EW'(OUT_LIMIT));
  assign ram_we    = take && in_ent_r;

  always_comb begin
    in_ent_nxt    = in_ent_r;
    cnt_nxt       = cnt_r;
    ri_nxt        = ri_r;
    len_nxt       = len_r;
    last_nxt      = last_r;
    ecnt_nxt      = ecnt_base;
    p_valid_nxt   = p_valid_r;
    p_byte_nxt    = p_byte_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mask_nxt      = mask_r;
    is_hash_nxt   = is_hash_r;
    np_nxt        = np_r;
    b16_nxt       = b16_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    if (cmd.accept) begin
      last_nxt = in_data.end_of_text;
      ri_nxt   = '0;
    end
    if (cmd.rp_start) begin
      len_nxt    = cnt_r;
      in_ent_nxt = 1'b0;
      cnt_nxt    = '0;
      ri_nxt     = '0;
    end
    if (cmd.close) begin
      in_ent_nxt = 1'b0;
      cnt_nxt    = '0;
    end
    if (cmd.ri_inc) ri_nxt = ri_r + CW'(1);

    if (take) begin
      if (!in_ent_r) begin
        if (tb == CH_AMP) begin
          in_ent_nxt  = 1'b1;
          cnt_nxt     = '0;
          mask_nxt    = '1;
          is_hash_nxt = 1'b0;
          np_nxt      = NP_BASE;
          b16_nxt     = 1'b0;
          neg_nxt     = 1'b0;
          mag_nxt     = 8'd0;
        end
      end else begin
        cnt_nxt  = cnt_r + CW'(1);
        mask_nxt = mask_upd;
        if (cnt_r == '0) begin
          is_hash_nxt = (tb == CH_HASH);
          np_nxt      = NP_BASE;
        end else begin
          np_nxt  = ps_np;
          b16_nxt = ps_b16;
          neg_nxt = ps_neg;
          mag_nxt = ps_mag;
        end
      end
    end

    // hold the newest item back so the last one can be flagged
    if (do_emit) begin
      if (p_valid_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{out_byte: p_byte_r, out_last: 1'b0};
      end
      p_byte_nxt  = em_b;
      p_valid_nxt = 1'b1;
      ecnt_nxt    = ecnt_base + EW'(1);
    end
    if (cmd.flush && p_valid_r) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{out_byte: p_byte_r, out_last: last_r};
      p_valid_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ent_r    <= 1'b0;
      cnt_r       <= '0;
      ri_r        <= '0;
      len_r       <= '0;
      last_r      <= 1'b0;
      ecnt_r      <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_ent_r    <= in_ent_nxt;
      cnt_r       <= cnt_nxt;
      ri_r        <= ri_nxt;
      len_r       <= len_nxt;
      last_r      <= last_nxt;
      ecnt_r      <= ecnt_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_byte_r   <= p_byte_nxt;
    out_data_r <= out_data_nxt;
    mask_r     <= mask_nxt;
    is_hash_r  <= is_hash_nxt;
    np_r       <= np_nxt;
    b16_r      <= b16_nxt;
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign stat.semi      = in_ent_r && (in_data.text_byte == CH_SEMI);
  assign stat.ovf       = in_ent_r && (cnt_r == CW'(MAX_SPAN - 1));
  assign stat.name_hit  = hit;
  assign stat.is_hash   = is_hash_r && (cnt_r != '0);
  assign stat.ri_at_len = (ri_r == len_r);
  assign stat.ri_at_cnt = (ri_r == cnt_r);
  assign stat.txt_last  = (ri_r == CW'(text_len(hit_idx)) - CW'(1));
  assign stat.emit_ok   = emit_ok;
  assign stat.flush_ok  = emit_ok;
  assign stat.in_ent    = in_ent_r;
  assign stat.last      = last_r;
  assign stat.p_valid   = p_valid_r;

`ifndef SYNTHESIS
  a_span_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_SPAN)) else $error("span count past capacity");
  a_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> cnt_r < CW'(MAX_SPAN)) else $error("span write beyond store");
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    em_req |-> emit_ok) else $error("item emitted with no room");
  a_emit_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ecnt_r <= EW'(OUT_LIMIT)) else $error("result count past limit");
`endif

endmodule
`default_nettype wire

@@ sv/html_entity_decoder_core.sv @@
// HTML entity decoder top level: hed_ctrl sequencer plus hed_dp datapath.
// A plain byte passes through accept, check and flush into the output register.
// Expanded characters are emitted from the resolve step; each byte replayed or
// copied from the span store takes a RAM read and then a use step; an overflow
// replay holds the input off until it is done. Results appear in the cycle after
// they leave the pending stage; a stalled out channel stalls the sequencer.
// Synchronous active-low reset, no clearing pass.
`default_nettype none
module html_entity_decoder_core #(
  parameter int MAX_SPAN = hed_pkg::MAX_SPAN_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire hed_pkg::hed_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output hed_pkg::hed_out_t     out_data
);
  import hed_pkg::*;

  hed_cmd_t  cmd;
  hed_stat_t stat;

  hed_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hed_dp #(.MAX_SPAN(MAX_SPAN)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !stat.p_valid) else $error("pending item left at accept");
  a_take_one: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.take_in && cmd.take_ram)) else $error("two take sources at once");
  a_flush_alone: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |-> !cmd.emit_en && !cmd.take_in && !cmd.take_ram)
    else $error("flush collides with emit");
`endif

endmodule
`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for html_entity_decoder_core: random and directed text
// through a behavioral entity decoder, results compared in order. Needs hed_pkg.
module tb;
  import hed_pkg::*;

  localparam int SPAN = 20;
  localparam int QCAP = 2 * SPAN + 2;
  localparam int STALL_LIMIT = 20000;

  class entity_scoreboard;
    string names [18] = '{"amp", "lt", "gt", "quot", "apos", "nbsp", "copy", "reg",
      "mdash", "ndash", "hellip", "bull", "laquo", "raquo", "euro", "pound", "yen", "cent"};
    string texts [18] = '{"&", "<", ">", "\"", "'", " ", "(c)", "(r)", "--",
      "-", "...", "*", "<<", ">>", "EUR", "GBP", "JPY", "c"};
    logic [7:0] held [SPAN];
    int held_n;
    bit in_ent;
    logic [7:0] step_bytes [$];
    hed_out_t decoded_q [$];
    int errors;

    function void put(logic [7:0] b);
      if (step_bytes.size() < OUT_LIMIT) step_bytes.push_back(b);
    endfunction

    function logic [7:0] lc(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function int dval(logic [7:0] c, int base);
      if (c >= "0" && c <= "9") return c - "0";
      if (base == 16 && lc(c) >= "a" && lc(c) <= "f") return lc(c) - "a" + 10;
      return -1;
    endfunction

    function logic [7:0] number_byte();
      int i, base, mag, d;
      bit neg;
      i = 1; base = 10; mag = 0; neg = 0;
      if (held_n > 1 && lc(held[1]) == "x") begin
        base = 16; i = 2;
      end
      while (i < held_n && (held[i] == " " || (held[i] >= 9 && held[i] <= 13))) i++;
      if (i < held_n && (held[i] == "+" || held[i] == "-")) begin
        neg = (held[i] == "-"); i++;
      end
      if (base == 16 && i + 2 < held_n && held[i] == "0" && lc(held[i+1]) == "x" &&
          dval(held[i+2], 16) >= 0) i += 2;
      while (i < held_n) begin
        d = dval(held[i], base);
        if (d < 0) break;
        mag = mag * base + d;
        if (mag > 128) mag = 128;
        i++;
      end
      if (!neg && mag >= 1 && mag <= 127) return mag[7:0];
      return CH_QMARK;
    endfunction

    function void resolve();
      bit same;
      for (int k = 0; k < 18; k++) begin
        same = (names[k].len() == held_n);
        for (int i = 0; same && i < held_n; i++)
          if (lc(held[i]) != names[k][i]) same = 0;
        if (same) begin
          for (int i = 0; i < texts[k].len(); i++) put(texts[k][i]);
          return;
        end
      end
      if (held_n > 0 && held[0] == CH_HASH) begin
        put(number_byte());
        return;
      end
      put(CH_AMP);
      for (int i = 0; i < held_n; i++) put(held[i]);
      put(CH_SEMI);
    endfunction

    // true when the span fills without a semicolon
    function bit take(logic [7:0] b);
      if (!in_ent) begin
        if (b == CH_AMP) begin
          in_ent = 1; held_n = 0;
        end else put(b);
        return 0;
      end
      if (b == CH_SEMI) begin
        resolve();
        in_ent = 0; held_n = 0;
        return 0;
      end
      if (held_n < SPAN) held[held_n++] = b;
      return held_n >= SPAN;
    endfunction

    function void feed(logic [7:0] src [$]);
      logic [7:0] pend [$];
      logic [7:0] tmp [$];
      int pos;
      pend = src;
      while (pend.size() > QCAP) void'(pend.pop_back());
      pos = 0;
      while (pos < pend.size()) begin
        if (take(pend[pos++])) begin
          tmp.delete();
          for (int i = 0; i < held_n; i++) tmp.push_back(held[i]);
          for (int i = pos; i < pend.size() && tmp.size() < QCAP; i++) tmp.push_back(pend[i]);
          pend = tmp;
          pos = 0;
          in_ent = 0; held_n = 0;
          put(CH_AMP);
        end
      end
    endfunction

    function void note_input(hed_in_t it);
      logic [7:0] one [$];
      logic [7:0] cp [$];
      hed_out_t r;
      step_bytes.delete();
      one.push_back(it.text_byte);
      feed(one);
      if (it.end_of_text) begin
        while (in_ent) begin
          cp.delete();
          for (int i = 0; i < held_n; i++) cp.push_back(held[i]);
          in_ent = 0; held_n = 0;
          put(CH_AMP);
          feed(cp);
        end
      end
      foreach (step_bytes[i]) begin
        r.out_byte = step_bytes[i];
        r.out_last = it.end_of_text && (i == step_bytes.size() - 1);
        decoded_q.push_back(r);
      end
    endfunction

    function void check(hed_out_t r);
      hed_out_t e;
      if (decoded_q.size() == 0) begin
        $error("unexpected item: out_byte %h out_last %b", r.out_byte, r.out_last);
        errors++;
        return;
      end
      e = decoded_q.pop_front();
      if (r.out_byte !== e.out_byte) begin
        $error("out_byte: expected %h actual %h", e.out_byte, r.out_byte);
        errors++;
      end
      if (r.out_last !== e.out_last) begin
        $error("out_last: expected %b actual %b", e.out_last, r.out_last);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, in_valid, in_ready, out_valid, out_ready;
  hed_in_t in_data;
  hed_out_t out_data;

  html_entity_decoder_core DUT (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  entity_scoreboard sb = new();
  hed_in_t text_q [$];
  int accepted = 0;
  int idle_cycles = 0;
  bit calm = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  task automatic add_text(string s, bit last);
    hed_in_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.text_byte = s[i];
      it.end_of_text = last && (i == s.len() - 1);
      text_q.push_back(it);
    end
  endtask

  function automatic string rand_case(string s);
    string t;
    t = s;
    for (int i = 0; i < t.len(); i++)
      if ($urandom_range(1, 0) && t[i] >= "a" && t[i] <= "z") t[i] = t[i] - 32;
    return t;
  endfunction

  function automatic string rand_number();
    string t, dg;
    bit hex;
    int n;
    hex = $urandom_range(1, 0);
    dg = hex ? "0123456789abcdefABCDEF" : "0123456789";
    t = hex ? ($urandom_range(1, 0) ? "#x" : "#X") : "#";
    if ($urandom_range(3, 0) == 0) t = {t, $urandom_range(1, 0) ? " " : "\t"};
    case ($urandom_range(5, 0))
      0: t = {t, "-"};
      1: t = {t, "+"};
      default: ;
    endcase
    if (hex && $urandom_range(3, 0) == 0) t = {t, "0x"};
    n = $urandom_range(4, 0);
    for (int i = 0; i < n; i++) t = {t, string'(dg[$urandom_range(dg.len() - 1, 0)])};
    if ($urandom_range(4, 0) == 0) t = {t, "z"};
    return t;
  endfunction

  function automatic logic [7:0] rand_plain();
    logic [7:0] b;
    do b = $urandom_range(255, 0); while (b == CH_AMP || b == CH_SEMI);
    return b;
  endfunction

  task automatic add_random_segment();
    string t;
    bit last;
    int n;
    last = ($urandom_range(3, 0) == 0);
    case ($urandom_range(9, 0))
      0, 1, 2: t = {"&", rand_case(sb.names[$urandom_range(17, 0)]), ";"};
      3, 4: t = {"&", rand_number(), ";"};
      5: begin
        t = "&";
        n = $urandom_range(26, 18);
        for (int i = 0; i < n; i++)
          t = {t, string'($urandom_range(7, 0) == 0 ? CH_AMP : rand_plain())};
      end
      6: begin
        t = "&";
        n = $urandom_range(4, 0);
        for (int i = 0; i < n; i++) t = {t, string'(rand_plain())};
        last = 1;
      end
      7: begin
        t = "";
        n = $urandom_range(3, 1);
        for (int i = 0; i < n; i++) t = {t, string'(8'($urandom_range(255, 0)))};
      end
      default: begin
        t = "";
        n = $urandom_range(5, 1);
        for (int i = 0; i < n; i++) t = {t, string'(rand_plain())};
      end
    endcase
    add_text(t, last);
  endtask

  // receiver: random stalls, one long hold-off while the sender keeps offering
  initial begin
    out_ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (accepted >= 120 && idle_cycles == 0) begin
        out_ready <= 0;
        idle_cycles = 1;
        repeat (400) @(posedge clk);
      end
      out_ready <= calm ? 1'b1 : ($urandom_range(99, 0) >= 28);
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready) sb.check(out_data);

  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    hed_in_t it;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    add_text("a&amp;&LT;&gT;&quot;&apos;&nbsp;", 0);
    add_text("&copy;&reg;&mdash;&ndash;&hellip;&bull;&laquo;&raquo;", 0);
    add_text("&euro;&pound;&yen;&cent;&bogus;&;", 1);
    add_text("&#65;&#x7f;&#X41;&#0;&#128;&#-5;&# +9;&#x0x2A;&#;&#12z;", 1);
    add_text("&abcdefghijklmnopqrstuvw;", 0);
    add_text("&a&b&c", 1);
    it.text_byte = 8'h00; it.end_of_text = 0; text_q.push_back(it);
    it.text_byte = 8'hff; it.end_of_text = 1; text_q.push_back(it);
    while (text_q.size() < 380) add_random_segment();
    it.text_byte = "x"; it.end_of_text = 1; text_q.push_back(it);

    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (text_q[k]) begin
      calm = (k >= 200 && k < 290);
      while (!calm && $urandom_range(99, 0) < 28) begin
        in_valid <= 0;
        @(posedge clk);
      end
      in_valid <= 1;
      in_data <= text_q[k];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      sb.note_input(text_q[k]);
      accepted++;
    end
    in_valid <= 0;
    while (sb.decoded_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.decoded_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

@@ files.f @@
sv/hed_pkg.sv
sv/hed_ram.sv
sv/hed_ctrl.sv
sv/hed_dp.sv
sv/html_entity_decoder_core.sv
test/tb.sv
